/* design/greedy_box_suppression_defines.svh */
// Assertion macros for the greedy box suppression block.
// Included by the top level; expects clk and rst_n in scope.
`ifndef GREEDY_BOX_SUPPRESSION_DEFINES_SVH
`define GREEDY_BOX_SUPPRESSION_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GBS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define GBS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/gbs_pkg.sv */
// Shared types for the greedy box suppression block.
// No dependencies; used by the overlap pipeline and the top level.
package gbs_pkg;

  typedef struct packed {
    logic signed [14:0] x;
    logic signed [14:0] y;
    logic        [13:0] w;
    logic        [13:0] h;
  } box_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } gbs_state_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } pipe_stat_t;

endpackage

/* design/gbs_in_if.sv */
// Input request channel of the greedy box suppression block.
// Carries valid, ready and one box; no dependencies.
interface gbs_in_if;
  logic               valid;
  logic               ready;
  logic               first_of_set;
  logic signed [14:0] box_x;
  logic signed [14:0] box_y;
  logic        [13:0] box_w;
  logic        [13:0] box_h;

  modport source (output valid, first_of_set, box_x, box_y, box_w, box_h, input ready);
  modport sink (input valid, first_of_set, box_x, box_y, box_w, box_h, output ready);
endinterface

/* design/gbs_out_if.sv */
// Result request channel of the greedy box suppression block.
// Carries valid, ready and one decision; no dependencies.
interface gbs_out_if;
  logic       valid;
  logic       ready;
  logic       keep;
  logic [5:0] kept_slot;
  logic       store_overflow;
  logic [9:0] item_index;

  modport source (output valid, keep, kept_slot, store_overflow, item_index, input ready);
  modport sink (input valid, keep, kept_slot, store_overflow, item_index, output ready);
endinterface

/* design/gbs_iou_pipe.sv */
// Four-stage overlap test of the current box against one kept box per cycle.
// Depends on gbs_pkg for box_t and pipe_stat_t.
module gbs_iou_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               kept_vld,
  input  gbs_pkg::box_t      kept_box,
  input  gbs_pkg::box_t      cur_box,
  input  logic        [15:0] iou_threshold,
  output gbs_pkg::pipe_stat_t stat
);
  import gbs_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;

  // stage 1: overlap extents
  logic signed [15:0] c_x0, c_x1, k_x0, k_x1, c_y0, c_y1, k_y0, k_y1;
  logic signed [15:0] min_x1, max_x0, min_y1, max_y0;
  logic signed [16:0] ow_s, oh_s;
  logic        [13:0] ow_nxt, oh_nxt;
  logic        [13:0] ow_r, oh_r, kw_r, kh_r;

  // stage 2..4
  logic [27:0] area_cur_r;
  logic [27:0] inter_r, ak_r;
  logic [27:0] inter_c_r;
  logic [28:0] uni_r;
  logic [43:0] lhs_r;
  logic [44:0] prod_r;

  always_comb begin
    c_x0 = {cur_box.x[14], cur_box.x};
    c_y0 = {cur_box.y[14], cur_box.y};
    k_x0 = {kept_box.x[14], kept_box.x};
    k_y0 = {kept_box.y[14], kept_box.y};
    c_x1 = c_x0 + signed'({2'b00, cur_box.w});
    c_y1 = c_y0 + signed'({2'b00, cur_box.h});
    k_x1 = k_x0 + signed'({2'b00, kept_box.w});
    k_y1 = k_y0 + signed'({2'b00, kept_box.h});
    min_x1 = (c_x1 < k_x1) ? c_x1 : k_x1;
    max_x0 = (c_x0 > k_x0) ? c_x0 : k_x0;
    min_y1 = (c_y1 < k_y1) ? c_y1 : k_y1;
    max_y0 = (c_y0 > k_y0) ? c_y0 : k_y0;
    ow_s = {min_x1[15], min_x1} - {max_x0[15], max_x0};
    oh_s = {min_y1[15], min_y1} - {max_y0[15], max_y0};
    // a positive extent never exceeds the narrower box, so 14 bits hold it
    ow_nxt = (!ow_s[16] && (ow_s != 17'sd0)) ? ow_s[13:0] : 14'd0;
    oh_nxt = (!oh_s[16] && (oh_s != 17'sd0)) ? oh_s[13:0] : 14'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= kept_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    area_cur_r <= cur_box.w * cur_box.h;
    ow_r       <= ow_nxt;
    oh_r       <= oh_nxt;
    kw_r       <= kept_box.w;
    kh_r       <= kept_box.h;
    inter_r    <= ow_r * oh_r;
    ak_r       <= kw_r * kh_r;
    uni_r      <= {1'b0, area_cur_r} + {1'b0, ak_r} - {1'b0, inter_r};
    inter_c_r  <= inter_r;
    prod_r     <= iou_threshold * uni_r;
    lhs_r      <= {inter_c_r, 16'h0000};
  end

  assign stat.busy = v1_r | v2_r | v3_r | v4_r;
  assign stat.hit  = v4_r && ({1'b0, lhs_r} > prod_r);

endmodule

/* design/greedy_box_suppression.sv */
// Greedy box suppression: boxes arrive sorted by descending score, one request
// at a time; each is tested by intersection over union against every box kept
// in the current set and kept only if no ratio exceeds iou_threshold/65536.
// Each accepted item is scanned, drained and then its result is loaded, and the next
// request is accepted in the cycle after the result is loaded: the kept store is
// one memory with a single read port, read one entry a cycle into a four-stage
// overlap pipeline that then drains. A new box is accepted while the previous
// result still waits on out_ch. first_of_set empties the kept list; a kept box
// that finds the store full is flagged with store_overflow and not stored.
// Configuration is to be written only while idle; the block does not enforce it.
// Depends on gbs_pkg, gbs_in_if, gbs_out_if, gbs_iou_pipe and the defines header.
module greedy_box_suppression #(
  parameter int MAX_KEPT  = 64,
  parameter int MAX_ITEMS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  gbs_in_if.sink      in_ch,
  gbs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import gbs_pkg::*;
  `include "greedy_box_suppression_defines.svh"

  localparam int IDX_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W   = $clog2(MAX_KEPT + 1);
  localparam int POS_CAP = ((MAX_ITEMS - 1) < 1023) ? (MAX_ITEMS - 1) : 1023;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_KEPT);
  localparam logic [9:0]       POS_MAX = 10'(POS_CAP);

  gbs_state_t state_r, state_nxt;

  logic [15:0]      thr_r;
  box_t             cur_r;
  logic             keep_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] rd_idx_r;
  logic [9:0]       pos_r;
  logic [9:0]       item_idx_r;
  box_t             rd_data_r;
  logic             rd_vld_r;

  logic             out_valid_r;
  logic             out_keep_r;
  logic [5:0]       out_slot_r;
  logic             out_ovf_r;
  logic [9:0]       out_idx_r;

  logic             accept;
  logic             rd_en;
  logic             load_out;
  logic             room;
  logic             mem_we;
  logic [CNT_W-1:0] cnt_base;
  logic [9:0]       pos_base;
  pipe_stat_t       stat;

  box_t mem [MAX_KEPT];

  assign accept   = in_ch.valid && in_ch.ready;
  assign room     = (cnt_r < CNT_MAX);
  assign mem_we   = load_out && keep_r && room;
  assign cnt_base = in_ch.first_of_set ? '0 : cnt_r;
  assign pos_base = in_ch.first_of_set ? 10'd0 : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // hold off requests while in reset
        in_ch.ready = rst_n;
        if (in_ch.valid && rst_n) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_r < cnt_r) begin
          rd_en = 1'b1;
        end else begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !stat.busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // kept store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IDX_W-1:0]] <= cur_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  gbs_iou_pipe u_pipe (
    .clk           (clk),
    .rst_n         (rst_n),
    .kept_vld      (rd_vld_r),
    .kept_box      (rd_data_r),
    .cur_box       (cur_r),
    .iou_threshold (thr_r),
    .stat          (stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= 16'd29491;
      cnt_r       <= '0;
      pos_r       <= 10'd0;
      rd_idx_r    <= '0;
      rd_vld_r    <= 1'b0;
      keep_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      rd_vld_r <= rd_en;
      if (accept) begin
        keep_r     <= 1'b1;
        cnt_r      <= cnt_base;
        rd_idx_r   <= '0;
        item_idx_r <= pos_base;
        pos_r      <= (pos_base < POS_MAX) ? pos_base + 10'd1 : pos_base;
      end else begin
        if (rd_en) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
        end
        // drop the box on any overlap above threshold
        if (stat.hit) begin
          keep_r <= 1'b0;
        end
        if (mem_we) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r.x <= in_ch.box_x;
      cur_r.y <= in_ch.box_y;
      cur_r.w <= in_ch.box_w;
      cur_r.h <= in_ch.box_h;
    end
    if (load_out) begin
      out_keep_r <= keep_r;
      out_ovf_r  <= keep_r && !room;
      out_slot_r <= (keep_r && room) ? 6'(cnt_r) : 6'd0;
      out_idx_r  <= item_idx_r;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.keep           = out_keep_r;
  assign out_ch.kept_slot      = out_slot_r;
  assign out_ch.store_overflow = out_ovf_r;
  assign out_ch.item_index     = out_idx_r;

  `GBS_ASSERT_NXT(a_accept_starts_scan, accept, state_r == ST_SCAN, "accept did not start a scan")
  `GBS_ASSERT_NXT(a_first_clears, accept && in_ch.first_of_set, cnt_r == '0, "set start kept entries")
  `GBS_ASSERT_IMP(a_read_in_range, rd_en, rd_idx_r < cnt_r && state_r == ST_SCAN, "read past count")
  `GBS_ASSERT_IMP(a_done_drained, state_r == ST_DONE, !stat.busy && !rd_vld_r, "result before drain")

endmodule
